>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the traffic light block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define TLC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked implication with asynchronous active-low reset disable.
`define TLC_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: assertion failed");

`endif

>>> sv/tlc_pkg.sv
// Types, constants and helper functions for the traffic light countdown block.
`default_nettype none

package tlc_pkg;

    typedef logic [7:0] lamp_t;
    typedef logic [6:0] seg_t;
    typedef logic [6:0] secs_t;
    typedef logic [7:0] tps_t;
    typedef logic [2:0] cfg_index_t;
    typedef logic [7:0] cfg_data_t;

    typedef enum logic [3:0] {
        PH_A_GREEN  = 4'b0001,
        PH_A_YELLOW = 4'b0010,
        PH_B_GREEN  = 4'b0100,
        PH_B_YELLOW = 4'b1000
    } phase_t;

    localparam cfg_index_t REG_TICKS_PER_SECOND = 3'd0;
    localparam cfg_index_t REG_A_GREEN_SECONDS  = 3'd1;
    localparam cfg_index_t REG_B_RED_SECONDS    = 3'd2;
    localparam cfg_index_t REG_A_YELLOW_SECONDS = 3'd3;
    localparam cfg_index_t REG_B_GREEN_SECONDS  = 3'd4;
    localparam cfg_index_t REG_B_YELLOW_SECONDS = 3'd5;

    localparam tps_t  TPS_RESET        = 8'd100;
    localparam secs_t A_GREEN_RESET    = 7'd30;
    localparam secs_t B_RED_RESET      = 7'd35;
    localparam secs_t A_YELLOW_RESET   = 7'd5;
    localparam secs_t B_GREEN_RESET    = 7'd15;
    localparam secs_t B_YELLOW_RESET   = 7'd5;
    localparam secs_t COUNTDOWN_RESET  = 7'd30;

    localparam lamp_t LAMPS_A_GREEN  = 8'hD7;
    localparam lamp_t LAMPS_A_YELLOW = 8'hB7;
    localparam lamp_t LAMPS_B_GREEN  = 8'h7D;
    localparam lamp_t LAMPS_B_YELLOW = 8'h7B;

    localparam seg_t SEG_BLANK = 7'h00;

    // floor(v / 10) == (v * 205) >> 11 for every 7-bit v
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    function automatic lamp_t lamps_of(input phase_t ph);
        lamp_t l;
        case (ph)
            PH_A_GREEN:  l = LAMPS_A_GREEN;
            PH_A_YELLOW: l = LAMPS_A_YELLOW;
            PH_B_GREEN:  l = LAMPS_B_GREEN;
            PH_B_YELLOW: l = LAMPS_B_YELLOW;
            default:     l = LAMPS_A_GREEN;
        endcase
        return l;
    endfunction

    function automatic phase_t next_phase(input phase_t ph);
        phase_t n;
        case (ph)
            PH_A_GREEN:  n = PH_A_YELLOW;
            PH_A_YELLOW: n = PH_B_GREEN;
            PH_B_GREEN:  n = PH_B_YELLOW;
            PH_B_YELLOW: n = PH_A_GREEN;
            default:     n = PH_A_GREEN;
        endcase
        return n;
    endfunction

    // Common-cathode code; digits above nine show blank.
    function automatic seg_t seg_of(input logic [3:0] digit);
        seg_t s;
        case (digit)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Tens in [7:4], ones in [3:0].
    function automatic logic [7:0] split_digits(input secs_t v);
        logic [14:0] prod;
        logic [3:0]  tens;
        secs_t       ones;
        prod = 15'(v) * 15'(DIV10_MUL);
        tens = prod[14:DIV10_SHIFT];
        ones = v - 7'(7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

>>> sv/tlc_tick_if.sv
// Input channel carrying one timer tick per beat.
`default_nettype none

interface tlc_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

`default_nettype wire

>>> sv/tlc_result_if.sv
// Output channel carrying lamps, digit codes and the second flag per beat.
`default_nettype none

interface tlc_result_if;
    import tlc_pkg::*;

    logic  valid;
    logic  ready;
    lamp_t lamps;
    seg_t  seg_a_tens;
    seg_t  seg_a_ones;
    seg_t  seg_b_tens;
    seg_t  seg_b_ones;
    logic  second_elapsed;

    modport source (output valid, output lamps, output seg_a_tens, output seg_a_ones,
                    output seg_b_tens, output seg_b_ones, output second_elapsed,
                    input ready);
    modport sink   (input valid, input lamps, input seg_a_tens, input seg_a_ones,
                    input seg_b_tens, input seg_b_ones, input second_elapsed,
                    output ready);
endinterface

`default_nettype wire

>>> sv/tlc_cfg_if.sv
// Configuration write channel: register index and data per beat.
`default_nettype none

interface tlc_cfg_if;
    import tlc_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/two_way_traffic_light_countdown_top.sv
// An accepted tick beat is held in the input register until the result register is free.
// Throughput: one tick beat per cycle while results are taken; the input and result
// registers decouple the sides; an empty input stage takes a beat while results wait.
// Reset (rst_n low, asynchronous): phase A green / B red, countdowns 30, lamps 0xD7,
// digits blank, prescaler 0, registers at their defaults, pipeline empty.
`default_nettype none
`include "assert_macros.svh"

module two_way_traffic_light_countdown_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tlc_tick_if.sink      tick_ch,
    tlc_result_if.source  result,
    tlc_cfg_if.sink       cfg
);
    import tlc_pkg::*;

    // configuration registers
    tps_t   tps_reg;
    secs_t  a_green_reg;
    secs_t  b_red_reg;
    secs_t  a_yellow_reg;
    secs_t  b_green_reg;
    secs_t  b_yellow_reg;

    // input stage
    logic   s1_valid_reg;
    logic   s1_tick_reg;

    // block state, which is also the result register
    tps_t   tick_count_reg;
    tps_t   tick_count_next;
    phase_t phase_reg;
    phase_t phase_next;
    secs_t  countdown_a_reg;
    secs_t  countdown_a_next;
    secs_t  countdown_b_reg;
    secs_t  countdown_b_next;
    lamp_t  lamps_reg;
    lamp_t  lamps_next;
    seg_t   seg_reg [4];
    seg_t   seg_next [4];
    logic   sec_reg;
    logic   out_valid_reg;

    logic   out_free;
    logic   s1_adv;
    logic   step;
    logic   sec;
    tps_t   count_inc;
    secs_t  dec_a;
    secs_t  dec_b;
    logic [7:0] digits_a;
    logic [7:0] digits_b;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg      <= TPS_RESET;
            a_green_reg  <= A_GREEN_RESET;
            b_red_reg    <= B_RED_RESET;
            a_yellow_reg <= A_YELLOW_RESET;
            b_green_reg  <= B_GREEN_RESET;
            b_yellow_reg <= B_YELLOW_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TICKS_PER_SECOND: tps_reg      <= cfg.data;
                REG_A_GREEN_SECONDS:  a_green_reg  <= cfg.data[6:0];
                REG_B_RED_SECONDS:    b_red_reg    <= cfg.data[6:0];
                REG_A_YELLOW_SECONDS: a_yellow_reg <= cfg.data[6:0];
                REG_B_GREEN_SECONDS:  b_green_reg  <= cfg.data[6:0];
                REG_B_YELLOW_SECONDS: b_yellow_reg <= cfg.data[6:0];
                default: ;
            endcase
        end
    end

    assign out_free      = !out_valid_reg || result.ready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign tick_ch.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_tick_reg  <= 1'b0;
        end
        else if (tick_ch.ready)
        begin
            s1_valid_reg <= tick_ch.valid;
            s1_tick_reg  <= tick_ch.tick;
        end
    end

    assign step      = s1_adv && s1_tick_reg;
    assign count_inc = tick_count_reg + 8'd1;
    assign sec       = step && (count_inc == tps_reg);
    // hold both countdowns at zero instead of wrapping
    assign dec_a     = (countdown_a_reg != '0) ? countdown_a_reg - 7'd1 : '0;
    assign dec_b     = (countdown_b_reg != '0) ? countdown_b_reg - 7'd1 : '0;

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        phase_next       = phase_reg;
        countdown_a_next = countdown_a_reg;
        countdown_b_next = countdown_b_reg;
        lamps_next       = lamps_reg;
        if (step)
        begin
            tick_count_next = sec ? '0 : count_inc;
        end
        if (sec)
        begin
            countdown_a_next = dec_a;
            countdown_b_next = dec_b;
            if (dec_a == '0)
            begin
                phase_next = next_phase(phase_reg);
                lamps_next = lamps_of(phase_next);
                case (phase_next)
                    PH_A_GREEN:
                    begin
                        countdown_a_next = a_green_reg;
                        countdown_b_next = b_red_reg;
                    end
                    PH_A_YELLOW:
                    begin
                        countdown_a_next = a_yellow_reg;
                        countdown_b_next = a_yellow_reg;
                    end
                    PH_B_GREEN:
                    begin
                        countdown_a_next = b_green_reg;
                        countdown_b_next = b_green_reg;
                    end
                    PH_B_YELLOW:
                    begin
                        countdown_a_next = b_yellow_reg;
                        countdown_b_next = b_yellow_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // re-encode the digits from the countdowns after any reload
    assign digits_a = split_digits(countdown_a_next);
    assign digits_b = split_digits(countdown_b_next);

    always_comb
    begin
        seg_next = seg_reg;
        if (sec)
        begin
            seg_next[0] = seg_of(digits_a[7:4]);
            seg_next[1] = seg_of(digits_a[3:0]);
            seg_next[2] = seg_of(digits_b[7:4]);
            seg_next[3] = seg_of(digits_b[3:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            phase_reg       <= PH_A_GREEN;
            countdown_a_reg <= COUNTDOWN_RESET;
            countdown_b_reg <= COUNTDOWN_RESET;
            lamps_reg       <= LAMPS_A_GREEN;
            for (int i = 0; i < 4; i++)
            begin
                seg_reg[i] <= SEG_BLANK;
            end
            sec_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                tick_count_reg  <= tick_count_next;
                phase_reg       <= phase_next;
                countdown_a_reg <= countdown_a_next;
                countdown_b_reg <= countdown_b_next;
                lamps_reg       <= lamps_next;
                seg_reg         <= seg_next;
                sec_reg         <= sec;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.lamps          = lamps_reg;
    assign result.seg_a_tens     = seg_reg[0];
    assign result.seg_a_ones     = seg_reg[1];
    assign result.seg_b_tens     = seg_reg[2];
    assign result.seg_b_ones     = seg_reg[3];
    assign result.second_elapsed = sec_reg;

    // a completed second clears the prescaler
    `TLC_ASSERT_IMPL(a_sec_clears_prescaler, clk, rst_n, sec, tick_count_reg == '0)
    // the phase moves only at a completed second
    `TLC_ASSERT_IMPL(a_phase_only_on_sec, clk, rst_n, !sec, $stable(phase_reg))
    // countdowns and lamps hold unless a tick beat is processed
    `TLC_ASSERT_IMPL(a_state_holds_when_idle, clk, rst_n, !s1_adv,
        $stable(countdown_a_reg) && $stable(countdown_b_reg) && $stable(lamps_reg))
    // lamps always match the current phase
    `TLC_ASSERT(a_lamps_match_phase, clk, rst_n, lamps_reg == lamps_of(phase_reg))

endmodule

`default_nettype wire
